// File: design/tile_mass_moment_accumulator_core_assert.svh
// assertion macros for the tile mass and moment accumulator
// expects signals clk and rst_n in the module that uses them
`ifndef TILE_MASS_MOMENT_ACCUMULATOR_CORE_ASSERT_SVH
`define TILE_MASS_MOMENT_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication
`define TMMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TMMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tmma_pkg.sv
// shared constants, types and helpers of the tile mass and moment accumulator
// no dependencies
package tmma_pkg;

  localparam int IMAGE_LOG2 = 9;
  localparam int TILE_LOG2  = 3;
  localparam int TLOG       = (TILE_LOG2 < IMAGE_LOG2) ? TILE_LOG2 : IMAGE_LOG2;
  localparam int IMG_W      = IMAGE_LOG2;
  localparam int TIDX_W     = (IMAGE_LOG2 > TLOG) ? (IMAGE_LOG2 - TLOG) : 1;
  localparam int TILES      = 1 << (IMAGE_LOG2 - TLOG);

  localparam int PIX_W  = 8;
  localparam int TXY_W  = 6;
  localparam int MASS_W = 14;
  localparam int MOM_W  = 23;
  localparam int CNT_W  = 7;

  localparam logic [IMG_W-1:0] TILE_MASK = IMG_W'((1 << TLOG) - 1);
  localparam logic [IMG_W-1:0] IMG_MAX   = {IMG_W{1'b1}};

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [MOM_W-1:0]  xmom;
    logic [MOM_W-1:0]  ymom;
    logic [CNT_W-1:0]  cnt;
  } acc_t;

  typedef struct packed {
    logic              en;
    logic [TIDX_W-1:0] addr;
    acc_t              data;
  } wr_t;

  typedef struct packed {
    logic [TXY_W-1:0]  tile_x;
    logic [TXY_W-1:0]  tile_y;
    logic [MASS_W-1:0] mass_sum;
    logic [MOM_W-1:0]  x_moment;
    logic [MOM_W-1:0]  y_moment;
    logic [CNT_W-1:0]  pixel_count;
  } res_t;

  function automatic logic [TIDX_W-1:0] tile_idx(input logic [IMG_W-1:0] c);
    return TIDX_W'(c >> TLOG);
  endfunction

endpackage

// File: design/tmma_ifs.sv
// valid/ready channel interfaces: pixel beats in, tile result beats out
// depends on tmma_pkg
interface tmma_pix_if import tmma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface tmma_res_if import tmma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TXY_W-1:0]  tile_x;
  logic [TXY_W-1:0]  tile_y;
  logic [MASS_W-1:0] mass_sum;
  logic [MOM_W-1:0]  x_moment;
  logic [MOM_W-1:0]  y_moment;
  logic [CNT_W-1:0]  pixel_count;

  modport source (output valid, output tile_x, output tile_y, output mass_sum,
                  output x_moment, output y_moment, output pixel_count, input ready);
  modport sink   (input valid, input tile_x, input tile_y, input mass_sum,
                  input x_moment, input y_moment, input pixel_count, output ready);
endinterface

// File: design/tmma_acc_mem.sv
// per-tile-column accumulator store, one write and one registered read per cycle
// entries read as zero until written; write-to-read bypass; depends on tmma_pkg
module tmma_acc_mem import tmma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [TIDX_W-1:0] rd_addr,
  output acc_t              rd_data,
  input  wr_t               wr
);

  acc_t             mem_r [TILES];
  logic [TILES-1:0] valid_r;
  acc_t             rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else if (!valid_r[rd_addr]) begin
        rd_data_r <= '0;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/tile_mass_moment_accumulator_core.sv
// tile mass and moment accumulator, top level
// depends on tmma_pkg, tmma_ifs, tmma_acc_mem and the assertion macro header
//
// in_bus carries one 8-bit unsigned pixel per beat, raster order, square image
// of 2**IMAGE_LOG2 pixels a side; column and row are counted inside the block.
// Pixels fall into square tiles of 2**TILE_LOG2 pixels a side. Per tile the
// block sums mass, x and y moments (pixel times global column or row) and the
// count of nonzero pixels. At a tile's bottom-right pixel, out_bus gets one beat
// with the tile coordinates and the sums if the count is nonzero; the tile's
// sums are cleared either way. After the last pixel a new image starts.
// Throughput: one pixel per cycle while out_bus is not stalled. A result beat
// is valid once the beat of the tile's last pixel has been taken into the input
// register and then accumulated and loaded into the result register.
// Partial sums of the tile row live in a small store with one entry per tile
// column, read as a segment starts and written back as it ends.
// Reset clears position counters, entry valid bits and the handshake state.
// While out_bus is stalled one result waits in the output register and the
// input register still takes one more pixel; then in_bus.ready drops.
`include "tile_mass_moment_accumulator_core_assert.svh"

module tile_mass_moment_accumulator_core import tmma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tmma_pix_if.sink   in_bus,
  tmma_res_if.source out_bus
);

  logic [IMG_W-1:0] col_r, col_nxt;
  logic [IMG_W-1:0] row_r, row_nxt;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [IMG_W-1:0] s1_col_r;
  logic [IMG_W-1:0] s1_row_r;

  acc_t acc_r, acc_nxt, base;
  res_t out_r;
  logic out_valid_r;

  logic in_acc, out_free, s1_fire;
  logic seg_first, seg_last, tile_end, emit;
  logic [PIX_W+IMG_W-1:0] prod_x, prod_y;

  logic              rd_en;
  logic [TIDX_W-1:0] rd_addr;
  acc_t              rd_data;
  wr_t               wr;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || out_free;

  // position counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      col_nxt = col_r + 1'b1;
      if (col_r == IMG_MAX) begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_bus.pixel;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
  end

  // fetch the partial sums when a tile segment starts
  assign rd_en   = in_acc && ((col_r & TILE_MASK) == '0);
  assign rd_addr = tile_idx(col_r);

  tmma_acc_mem u_acc_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // accumulate
  always_comb begin
    seg_first = (s1_col_r & TILE_MASK) == '0;
    seg_last  = (s1_col_r & TILE_MASK) == TILE_MASK;
    tile_end  = seg_last && ((s1_row_r & TILE_MASK) == TILE_MASK);
    base      = seg_first ? rd_data : acc_r;
    prod_x    = (PIX_W+IMG_W)'(s1_pix_r) * (PIX_W+IMG_W)'(s1_col_r);
    prod_y    = (PIX_W+IMG_W)'(s1_pix_r) * (PIX_W+IMG_W)'(s1_row_r);
    acc_nxt.mass = base.mass + MASS_W'(s1_pix_r);
    acc_nxt.xmom = base.xmom + MOM_W'(prod_x);
    acc_nxt.ymom = base.ymom + MOM_W'(prod_y);
    acc_nxt.cnt  = base.cnt + CNT_W'(s1_pix_r != '0);
    emit = s1_fire && tile_end && (acc_nxt.cnt != '0);

    wr.en   = s1_fire && seg_last;
    wr.addr = tile_idx(s1_col_r);
    wr.data = tile_end ? '0 : acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      acc_r <= acc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.tile_x      <= TXY_W'(tile_idx(s1_col_r));
      out_r.tile_y      <= TXY_W'(s1_row_r >> TLOG);
      out_r.mass_sum    <= acc_nxt.mass;
      out_r.x_moment    <= acc_nxt.xmom;
      out_r.y_moment    <= acc_nxt.ymom;
      out_r.pixel_count <= acc_nxt.cnt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.tile_x      = out_r.tile_x;
  assign out_bus.tile_y      = out_r.tile_y;
  assign out_bus.mass_sum    = out_r.mass_sum;
  assign out_bus.x_moment    = out_r.x_moment;
  assign out_bus.y_moment    = out_r.y_moment;
  assign out_bus.pixel_count = out_r.pixel_count;

  `TMMA_ASSERT_NOW(a_no_empty_result, out_bus.valid, out_bus.pixel_count != '0,
    "result beat with zero pixel count")
  `TMMA_ASSERT_NEXT(a_emit_shows, emit, out_valid_r,
    "finished tile did not reach the result register")
  `TMMA_ASSERT_NEXT(a_col_wrap, in_acc && (col_r == IMG_MAX), col_r == '0,
    "column counter did not wrap at line end")
  `TMMA_ASSERT_NOW(a_wb_at_seg_end, wr.en, s1_valid_r && seg_last,
    "write-back outside a segment end")

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// testbench for tile_mass_moment_accumulator_core: streams the first tile row
// and checks every tile result beat against a running model; uses tmma_pkg, tmma_ifs
module tb;
  import tmma_pkg::*;

  localparam int IMG_SIDE       = 1 << IMAGE_LOG2;
  localparam int TILE_SIDE      = 1 << TLOG;
  localparam int TOTAL_PIXELS   = TILE_SIDE * IMG_SIDE;
  localparam int RAND_START     = (TILE_SIDE - 1) * IMG_SIDE + 2 * TILE_SIDE;
  localparam int PHASE_B_START  = RAND_START + (TOTAL_PIXELS - RAND_START) / 3;
  localparam int PHASE_C_START  = RAND_START + 2 * (TOTAL_PIXELS - RAND_START) / 3;
  localparam int HOLD_AT        = PHASE_C_START + 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic [1:0] {TK_EMPTY, TK_FULL, TK_DENSE, TK_SPARSE} tile_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [12:0]      run;
    logic             typed;
    res_t             want;
  } pix_run_t;

  logic clk = 1'b0;
  logic rst_n;

  tmma_pix_if pix_bus ();
  tmma_res_if res_bus ();

  tile_mass_moment_accumulator_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (pix_bus),
    .out_bus (res_bus)
  );

  always #6 clk = ~clk;

  // first tile row: full tile at the left, single pixel closing the next tile
  pix_run_t pix_runs [17] = '{
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b0, '0}, '{8'd0, 13'd504, 1'b0, '0},
    '{8'd255, 13'd8, 1'b1, '{6'd0, 6'd0, 14'd16320, 23'd57120, 23'd57120, 7'd64}},
    '{8'd0, 13'd7, 1'b0, '0},
    '{8'd1, 13'd1, 1'b1, '{6'd1, 6'd0, 14'd1, 23'd15, 23'd7, 7'd1}}
  };

  logic [IMG_W-1:0] pos_col;
  logic [IMG_W-1:0] pos_row;
  acc_t             tile_sums [TILES];
  tile_kind_t       tile_kind [TILES];
  res_t             pending_tiles [$];

  int src_idle_pct  = 21;
  int sink_idle_pct = 51;
  bit hold_req      = 1'b0;
  int mismatches    = 0;
  int stall_cycles  = 0;

  function automatic bit advance_tile_sums(input logic [PIX_W-1:0] p, output res_t r);
    logic [TIDX_W-1:0] t;
    bit emit;
    t = TIDX_W'(pos_col >> TLOG);
    emit = 1'b0;
    r = '0;
    if (p != '0) begin
      tile_sums[t].mass = tile_sums[t].mass + p;
      tile_sums[t].xmom = tile_sums[t].xmom + p * pos_col;
      tile_sums[t].ymom = tile_sums[t].ymom + p * pos_row;
      tile_sums[t].cnt  = tile_sums[t].cnt + 1'b1;
    end
    if ((pos_col & TILE_MASK) == TILE_MASK && (pos_row & TILE_MASK) == TILE_MASK) begin
      if (tile_sums[t].cnt != '0) begin
        emit = 1'b1;
        r.tile_x      = TXY_W'(t);
        r.tile_y      = TXY_W'(pos_row >> TLOG);
        r.mass_sum    = tile_sums[t].mass;
        r.x_moment    = tile_sums[t].xmom;
        r.y_moment    = tile_sums[t].ymom;
        r.pixel_count = tile_sums[t].cnt;
      end
      tile_sums[t] = '0;
    end
    // position wraps at image end on its own
    if (pos_col == IMG_MAX) pos_row = pos_row + 1'b1;
    pos_col = pos_col + 1'b1;
    return emit;
  endfunction

  task automatic offer_pixel(input logic [PIX_W-1:0] p, input bit use_want, input res_t want);
    res_t got;
    bit emitted;
    while ($urandom_range(99) < src_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= p;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    emitted = advance_tile_sums(p, got);
    if (use_want) pending_tiles.push_back(want);
    else if (emitted) pending_tiles.push_back(got);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", fname, want, got);
    end
  endtask

  always @(posedge clk) begin : res_check
    res_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_tiles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: tile %0d,%0d", res_bus.tile_x, res_bus.tile_y);
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_x", want.tile_x, res_bus.tile_x);
        check_field("tile_y", want.tile_y, res_bus.tile_y);
        check_field("mass_sum", want.mass_sum, res_bus.mass_sum);
        check_field("x_moment", want.x_moment, res_bus.x_moment);
        check_field("y_moment", want.y_moment, res_bus.y_moment);
        check_field("pixel_count", want.pixel_count, res_bus.pixel_count);
      end
    end
    if (rst_n && ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready)))
      stall_cycles = 0;
    else if (rst_n)
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side, long hold-off when asked
  initial begin : sink_proc
    res_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial begin : pixel_source
    int n;
    int col;
    int pick;
    logic [PIX_W-1:0] pix;
    pos_col = '0;
    pos_row = '0;
    foreach (tile_sums[t]) tile_sums[t] = '0;
    foreach (tile_kind[t]) tile_kind[t] = TK_EMPTY;
    rst_n <= 1'b0;
    pix_bus.valid <= 1'b0;
    pix_bus.pixel <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    n = 0;
    foreach (pix_runs[i]) begin
      for (int k = 0; k < pix_runs[i].run; k++) begin
        offer_pixel(pix_runs[i].pixel, pix_runs[i].typed && k == pix_runs[i].run - 1,
                    pix_runs[i].want);
        n++;
      end
    end

    while (n < TOTAL_PIXELS) begin
      col = n % IMG_SIDE;
      if (n == PHASE_B_START) begin
        src_idle_pct  = 51;
        sink_idle_pct = 21;
      end
      if (n == PHASE_C_START) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (n == HOLD_AT) hold_req = 1'b1;
      // random part: pick a content kind per tile
      if (n == RAND_START) begin
        foreach (tile_kind[t]) begin
          pick = $urandom_range(99);
          tile_kind[t] = pick < 15 ? TK_EMPTY : pick < 25 ? TK_FULL :
                         pick < 60 ? TK_DENSE : TK_SPARSE;
        end
        tile_kind[TILES-1] = TK_FULL;
      end
      case (tile_kind[col / TILE_SIDE])
        TK_EMPTY: pix = '0;
        TK_FULL:  pix = '1;
        TK_DENSE: pix = PIX_W'($urandom_range(255));
        default:  pix = ($urandom_range(15) == 0) ? PIX_W'($urandom_range(255, 1)) : '0;
      endcase
      offer_pixel(pix, 1'b0, '0);
      n++;
    end
    pix_bus.valid <= 1'b0;

    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tiles.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
